>>> rtl/asb_pkg.sv
// ----------------------------------------------------------------------------
// asb_pkg
// Shared types and constants of the addition sequence builder.
// ----------------------------------------------------------------------------
package asb_pkg;

  // Fixed field widths of the result transaction
  localparam int unsigned IdxW = 8;
  localparam int unsigned ExpW = 15;
  localparam int unsigned StW  = 3;

  // Signed needle: an exponent minus an exponent or minus twice an exponent
  localparam int unsigned NeedleW = ExpW + 2;

  // Product of the two term factors (each at most 9 bits)
  localparam int unsigned FacW  = 9;
  localparam int unsigned ProdW = 2 * FacW;

  // Sequence kinds as written to the configuration register
  localparam logic KindTheta = 1'b0;
  localparam logic KindEta   = 1'b1;

  // Result status codes
  typedef enum logic [StW-1:0] {
    ST_FIRST  = 3'd0,
    ST_DOUBLE = 3'd1,
    ST_SUM    = 3'd2,
    ST_DBLSUM = 3'd3,
    ST_NONE   = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  // Which kind of recipe is being tried
  typedef enum logic [1:0] {
    PH_DOUBLE,
    PH_SUM,
    PH_DBLSUM
  } phase_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_TERM,
    S_KREAD,
    S_KWAIT,
    S_PROBE,
    S_CMP,
    S_CHECK
  } state_e;

endpackage

>>> rtl/addition_sequence_builder_unit.sv
// ----------------------------------------------------------------------------
// addition_sequence_builder_unit
// Produces the next exponent of a theta or eta sequence with an addition
// recipe found by binary search over the table of earlier terms.
// ----------------------------------------------------------------------------
// One input transaction gives one result transaction. The term table is a
// single-port-write, single-port-read synchronous memory, and every lookup
// goes through its one read port: a term is first multiplied out and stored,
// then each binary search reads one probe entry per step, and each candidate
// a of the sum scans is read from the table before its search. A first term
// or a full-table report needs no search; a term with index i ends early on
// a doubling hit and runs through the candidate scans when no recipe exists.
// Items are handled one at a time; a finished result sits in the output
// register while the next transaction is taken in.
module addition_sequence_builder_unit #(
  parameter int unsigned MAX_TERMS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        sequence_kind_i,
  // step requests
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [asb_pkg::IdxW-1:0]    term_index_o,
  output logic [asb_pkg::ExpW-1:0]    exponent_o,
  output logic [asb_pkg::IdxW-1:0]    first_index_o,
  output logic [asb_pkg::IdxW-1:0]    second_index_o,
  output logic [asb_pkg::StW-1:0]     status_o
);

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW = AW + 1;

  // Term table
  logic [asb_pkg::ExpW-1:0] mem [MAX_TERMS];
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [asb_pkg::ExpW-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [asb_pkg::ExpW-1:0] rdata_q;

  // Sequencer state
  asb_pkg::state_e  state_q, state_d;
  asb_pkg::phase_e  phase_q, phase_d;
  asb_pkg::status_e st_q, st_d;
  logic             busy_out_q, busy_out_d;   // result waiting to move out
  logic             kind_q;
  logic [CW-1:0]    next_q, next_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    k_q, k_d;
  logic [AW-1:0]    lo_q, lo_d;
  logic [AW-1:0]    hi_q, hi_d;
  logic [AW-1:0]    a_q, a_d;
  logic [AW-1:0]    b_q, b_d;
  logic [asb_pkg::ProdW-1:0] prod_q, prod_d;
  logic [asb_pkg::ExpW-1:0]  c_q, c_d;
  logic signed [asb_pkg::NeedleW-1:0] needle_q, needle_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic [asb_pkg::IdxW-1:0] oidx_q, oa_q, ob_q;
  logic [asb_pkg::ExpW-1:0] oexp_q;
  asb_pkg::status_e         ost_q;
  logic                     out_load;

  // Helpers
  logic                     in_fire;
  logic [CW-1:0]            cur_idx;
  logic [asb_pkg::FacW-1:0] i9, fac_a, fac_b;
  logic [asb_pkg::FacW:0]   eta_lin;
  logic [asb_pkg::ExpW-1:0] c_new;
  logic [AW:0]              mid_sum;
  logic [AW-1:0]            mid;
  logic [AW-1:0]            last_k;
  logic signed [asb_pkg::NeedleW-1:0] rd_s;
  logic [asb_pkg::ExpW:0]   twice;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == asb_pkg::S_IDLE) && !busy_out_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cur_idx     = restart_i ? '0 : next_q;

  // Term factors
  assign i9      = asb_pkg::FacW'(idx_q);
  assign eta_lin = 10'(3 * i9) + 10'd5;
  always_comb begin
    if (kind_q == asb_pkg::KindEta) begin
      fac_a = (i9 + 9'd2) >> 1;
      fac_b = asb_pkg::FacW'(eta_lin >> 1);
    end else begin
      fac_a = i9 + 9'd2;
      fac_b = i9 + 9'd2;
    end
  end
  assign c_new = (kind_q == asb_pkg::KindEta) ? asb_pkg::ExpW'(prod_q >> 1)
                                               : asb_pkg::ExpW'(prod_q >> 2);

  // Search helpers
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[AW:1];
  assign last_k  = idx_q - AW'(1);
  assign rd_s    = $signed({2'b00, rdata_q});
  assign twice   = {rdata_q, 1'b0};

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= asb_pkg::KindTheta;
    end else if (cfg_valid_i && cfg_ready_o) begin
      kind_q <= sequence_kind_i;
    end
  end

  // Table memory: one write and one registered read per cycle. Searches only
  // read entries below the current index, so no read meets a pending write.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Next state and datapath control
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    st_d       = st_q;
    busy_out_d = busy_out_q;
    next_d     = next_q;
    idx_d      = idx_q;
    k_d        = k_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    a_d        = a_q;
    b_d        = b_q;
    prod_d     = prod_q;
    c_d        = c_q;
    needle_d   = needle_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = c_new;
    mem_raddr  = lo_q;
    out_load   = 1'b0;

    // hand a finished result to the output register
    if (busy_out_q && (!out_valid_q || out_ready_i)) begin
      out_load   = 1'b1;
      busy_out_d = 1'b0;
    end

    case (state_q)
      asb_pkg::S_IDLE: begin
        if (in_fire) begin
          a_d = '0;
          b_d = '0;
          if (!restart_i && (next_q >= CW'(MAX_TERMS))) begin
            // table full: nothing stored
            idx_d      = '0;
            c_d        = '0;
            st_d       = asb_pkg::ST_FULL;
            busy_out_d = 1'b1;
          end else if (cur_idx == '0) begin
            idx_d      = '0;
            c_d        = asb_pkg::ExpW'(1);
            st_d       = asb_pkg::ST_FIRST;
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = asb_pkg::ExpW'(1);
            next_d     = CW'(1);
            busy_out_d = 1'b1;
          end else begin
            idx_d   = cur_idx[AW-1:0];
            state_d = asb_pkg::S_MUL;
          end
        end
      end

      asb_pkg::S_MUL: begin
        prod_d  = asb_pkg::ProdW'(fac_a) * asb_pkg::ProdW'(fac_b);
        state_d = asb_pkg::S_TERM;
      end

      // store the term, then try doubling if it is even
      asb_pkg::S_TERM: begin
        c_d       = c_new;
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = c_new;
        next_d    = CW'(idx_q) + CW'(1);
        st_d      = asb_pkg::ST_NONE;
        if (!c_new[0]) begin
          phase_d  = asb_pkg::PH_DOUBLE;
          needle_d = $signed(asb_pkg::NeedleW'(c_new >> 1));
          lo_d     = '0;
          hi_d     = last_k;
          state_d  = asb_pkg::S_PROBE;
        end else begin
          phase_d = asb_pkg::PH_SUM;
          k_d     = '0;
          state_d = asb_pkg::S_KREAD;
        end
      end

      asb_pkg::S_KREAD: begin
        mem_raddr = k_q;
        state_d   = asb_pkg::S_KWAIT;
      end

      // candidate a is in; form the needle or end the scan
      asb_pkg::S_KWAIT: begin
        lo_d = '0;
        hi_d = last_k;
        if (phase_q == asb_pkg::PH_SUM) begin
          needle_d = $signed({2'b00, c_q}) - rd_s;
          state_d  = asb_pkg::S_PROBE;
        end else if (twice > {1'b0, c_q}) begin
          st_d       = asb_pkg::ST_NONE;
          a_d        = '0;
          b_d        = '0;
          busy_out_d = 1'b1;
          state_d    = asb_pkg::S_IDLE;
        end else begin
          needle_d = $signed({2'b00, c_q}) - $signed({1'b0, twice});
          state_d  = asb_pkg::S_PROBE;
        end
      end

      asb_pkg::S_PROBE: begin
        if (lo_q < hi_q) begin
          mem_raddr = mid;
          state_d   = asb_pkg::S_CMP;
        end else begin
          mem_raddr = lo_q;
          state_d   = asb_pkg::S_CHECK;
        end
      end

      asb_pkg::S_CMP: begin
        if (rd_s < needle_q) begin
          lo_d = mid + AW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = asb_pkg::S_PROBE;
      end

      // search done: report a hit or move to the next candidate
      asb_pkg::S_CHECK: begin
        if (rd_s == needle_q) begin
          b_d        = lo_q;
          busy_out_d = 1'b1;
          state_d    = asb_pkg::S_IDLE;
          case (phase_q)
            asb_pkg::PH_DOUBLE: begin
              a_d  = lo_q;
              st_d = asb_pkg::ST_DOUBLE;
            end
            asb_pkg::PH_SUM: begin
              a_d  = k_q;
              st_d = asb_pkg::ST_SUM;
            end
            default: begin
              a_d  = k_q;
              st_d = asb_pkg::ST_DBLSUM;
            end
          endcase
        end else if (phase_q == asb_pkg::PH_DOUBLE) begin
          phase_d = asb_pkg::PH_SUM;
          k_d     = '0;
          state_d = asb_pkg::S_KREAD;
        end else if (k_q == last_k) begin
          if (phase_q == asb_pkg::PH_SUM) begin
            phase_d = asb_pkg::PH_DBLSUM;
            k_d     = '0;
            state_d = asb_pkg::S_KREAD;
          end else begin
            st_d       = asb_pkg::ST_NONE;
            a_d        = '0;
            b_d        = '0;
            busy_out_d = 1'b1;
            state_d    = asb_pkg::S_IDLE;
          end
        end else begin
          k_d     = k_q + AW'(1);
          state_d = asb_pkg::S_KREAD;
        end
      end

      default: begin
        state_d = asb_pkg::S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asb_pkg::S_IDLE;
      phase_q     <= asb_pkg::PH_DOUBLE;
      busy_out_q  <= 1'b0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      busy_out_q  <= busy_out_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    st_q     <= st_d;
    idx_q    <= idx_d;
    k_q      <= k_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    a_q      <= a_d;
    b_q      <= b_d;
    prod_q   <= prod_d;
    c_q      <= c_d;
    needle_q <= needle_d;
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oidx_q <= asb_pkg::IdxW'(idx_q);
      oexp_q <= c_q;
      oa_q   <= asb_pkg::IdxW'(a_q);
      ob_q   <= asb_pkg::IdxW'(b_q);
      ost_q  <= st_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign term_index_o   = oidx_q;
  assign exponent_o     = oexp_q;
  assign first_index_o  = oa_q;
  assign second_index_o = ob_q;
  assign status_o       = ost_q;

endmodule
